// ----- sv/assert_macros.svh -----
// Assertion helpers for the hash table RTL.
// ASSERT_RST checks on every clock edge outside reset; ASSERT_ALWAYS also during reset.
// ASSERT_RST expects signals named clk and rst, ASSERT_ALWAYS one named clk, in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define ASSERT_RST(label, prop, msg)

`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

// ----- sv/lpht_pkg.sv -----
package lpht_pkg;

  // Slot count must be a power of two: the home slot is the low hash bits.
  localparam int SLOTS     = 64;
  localparam int SLOT_BITS = $clog2(SLOTS);
  localparam int KEY_BITS  = 32;
  localparam int VAL_BITS  = 16;
  localparam int CNT_BITS  = $clog2(SLOTS + 1);
  localparam int OCC_BITS  = 7;

  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_GET   = 2'd1;
  localparam logic [1:0] OP_ERASE = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_REMOVED   = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] home_hash;
    logic [15:0] value_in;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] value_out;
    logic [6:0]  occupancy;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic load;    // capture the request, rewind the probe
    logic probe;   // issue slot reads and evaluate returned slots
    logic commit;  // update the table and load the response register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic skip;        // op code needs no probe
    logic probe_done;  // key hit, or every slot evaluated
    logic out_free;    // response register can take a new transaction
  } sts_t;

endpackage

// ----- sv/lpht_ram.sv -----
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/lpht_datapath.sv -----
`include "assert_macros.svh"

module lpht_datapath (
  input  logic          clk,
  input  logic          rst,
  input  lpht_pkg::req_t req,
  input  lpht_pkg::cmd_t cmd,
  output lpht_pkg::sts_t sts,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output lpht_pkg::rsp_t rsp
);

  // Captured request
  logic [1:0]                    op_r;
  logic [lpht_pkg::KEY_BITS-1:0] key_r;
  logic [lpht_pkg::VAL_BITS-1:0] val_r;

  // Probe address side
  logic [lpht_pkg::SLOT_BITS-1:0] pos;
  logic [lpht_pkg::SLOT_BITS:0]   issued;
  logic                           issue_ok;

  // Evaluation stage, in the cycle after the slot read
  logic                           s1_live;
  logic                           s1_valid;
  logic [lpht_pkg::SLOT_BITS-1:0] s1_pos;
  logic [lpht_pkg::SLOT_BITS-1:0] evals;
  logic                           eval_en;
  logic                           hit_now;

  logic                           found;
  logic [lpht_pkg::SLOT_BITS-1:0] hit_pos;
  logic [lpht_pkg::VAL_BITS-1:0]  hit_val;
  logic                           empty_seen;
  logic [lpht_pkg::SLOT_BITS-1:0] empty_pos;

  // Table state
  logic [lpht_pkg::SLOTS-1:0]     valid;
  logic [lpht_pkg::CNT_BITS-1:0]  used_count;
  logic [lpht_pkg::CNT_BITS-1:0]  used_count_next;

  logic [lpht_pkg::KEY_BITS-1:0]  key_rd;
  logic [lpht_pkg::VAL_BITS-1:0]  val_rd;
  logic [lpht_pkg::SLOT_BITS-1:0] ram_addr;
  logic                           ram_we;

  // Commit decode
  logic [2:0]                     status_c;
  logic [lpht_pkg::VAL_BITS-1:0]  vout_c;
  logic                           wr_c;
  logic                           set_c;
  logic                           clr_c;
  logic [lpht_pkg::SLOT_BITS-1:0] wr_pos;

  assign issue_ok = cmd.probe && (issued != (lpht_pkg::SLOT_BITS + 1)'(lpht_pkg::SLOTS));
  assign eval_en  = cmd.probe && s1_live;
  assign hit_now  = eval_en && s1_valid && (key_rd == key_r);
  assign wr_pos   = found ? hit_pos : empty_pos;
  assign ram_addr = cmd.commit ? wr_pos : pos;
  assign ram_we   = cmd.commit && wr_c;

  assign sts.skip       = (op_r != lpht_pkg::OP_SET) && (op_r != lpht_pkg::OP_GET) &&
                          (op_r != lpht_pkg::OP_ERASE);
  assign sts.probe_done = eval_en &&
                          (hit_now || (evals == lpht_pkg::SLOT_BITS'(lpht_pkg::SLOTS - 1)));
  assign sts.out_free   = !rsp_valid || !rsp_stall;

  lpht_ram #(.WIDTH(lpht_pkg::KEY_BITS), .DEPTH(lpht_pkg::SLOTS)) u_key_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (key_r),
    .rdata (key_rd)
  );

  lpht_ram #(.WIDTH(lpht_pkg::VAL_BITS), .DEPTH(lpht_pkg::SLOTS)) u_val_ram (
    .clk   (clk),
    .addr  (ram_addr),
    .we    (ram_we),
    .wdata (val_r),
    .rdata (val_rd)
  );

  always_comb begin
    status_c = lpht_pkg::ST_NOT_FOUND;
    vout_c   = '0;
    wr_c     = 1'b0;
    set_c    = 1'b0;
    clr_c    = 1'b0;
    case (op_r)
      lpht_pkg::OP_SET: begin
        if (found) begin
          status_c = lpht_pkg::ST_UPDATED;
          wr_c     = 1'b1;
        end else if (empty_seen) begin
          status_c = lpht_pkg::ST_INSERTED;
          wr_c     = 1'b1;
          set_c    = 1'b1;
        end else begin
          status_c = lpht_pkg::ST_FULL;
        end
      end
      lpht_pkg::OP_GET: begin
        if (found) begin
          status_c = lpht_pkg::ST_FOUND;
          vout_c   = hit_val;
        end
      end
      lpht_pkg::OP_ERASE: begin
        if (found) begin
          status_c = lpht_pkg::ST_REMOVED;
          vout_c   = hit_val;
          clr_c    = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    used_count_next = used_count;
    if (set_c) begin
      used_count_next = used_count + 1'b1;
    end else if (clr_c && (used_count != '0)) begin
      used_count_next = used_count - 1'b1;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= req.op;
      key_r      <= lpht_pkg::KEY_BITS'(req.key);
      val_r      <= req.value_in;
      pos        <= req.home_hash[lpht_pkg::SLOT_BITS-1:0];
      issued     <= '0;
      evals      <= '0;
      found      <= 1'b0;
      empty_seen <= 1'b0;
    end else begin
      if (issue_ok) begin
        pos    <= pos + 1'b1;
        issued <= issued + 1'b1;
      end
      if (eval_en) begin
        evals <= evals + 1'b1;
        if (hit_now) begin
          found   <= 1'b1;
          hit_pos <= s1_pos;
          hit_val <= val_rd;
        end else if (!s1_valid && !empty_seen) begin
          empty_seen <= 1'b1;
          empty_pos  <= s1_pos;
        end
      end
    end
    s1_valid <= valid[pos];
    s1_pos   <= pos;
    if (cmd.commit) begin
      rsp.status    <= status_c;
      rsp.value_out <= vout_c;
      rsp.occupancy <= lpht_pkg::OCC_BITS'(used_count_next);
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_live    <= 1'b0;
      valid      <= '0;
      used_count <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      s1_live <= issue_ok;
      if (cmd.commit) begin
        used_count <= used_count_next;
        if (set_c) begin
          valid[wr_pos] <= 1'b1;
        end
        if (clr_c) begin
          valid[wr_pos] <= 1'b0;
        end
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  `ASSERT_RST(a_commit_needs_room, cmd.commit |-> sts.out_free, "commit into a held response")
  `ASSERT_ALWAYS(a_count_matches_map, rst || (used_count == $countones(valid)), "occupancy drifted")
  `ASSERT_RST(a_insert_into_empty, cmd.commit && set_c |-> !valid[wr_pos], "insert over a live slot")
  `ASSERT_RST(a_rsp_from_commit, $rose(rsp_valid) |-> $past(cmd.commit), "response without commit")

endmodule

// ----- sv/lpht_ctrl.sv -----
module lpht_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  output lpht_pkg::cmd_t cmd,
  input  lpht_pkg::sts_t sts
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_PROBE  = 2'd1;
  localparam logic [1:0] S_FINISH = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign req_stall  = (state != S_IDLE);
  assign cmd.load   = (state == S_IDLE) && req_valid;
  assign cmd.probe  = (state == S_PROBE) && !sts.skip;
  assign cmd.commit = (state == S_FINISH) && sts.out_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts.skip || sts.probe_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- sv/linear_probe_hash_table_top.sv -----
// Channel   Direction  Payload          Handshake
// req       in         lpht_pkg::req_t  req_valid / req_stall
// rsp       out        lpht_pkg::rsp_t  rsp_valid / rsp_stall
//
// One transaction at a time. A request probes from its home slot on until
// its key is hit; a miss or a full table probes every slot, and the next
// request is taken once the sequencer is back in idle after the commit.
// The single port of the key/value RAMs gives one slot read per cycle
// along the probe.
// Reset clears the slot valid map and the count at once; no clearing pass.
// A stalled response holds in its register; the next request is taken and
// probed meanwhile, and only its commit waits for the register to drain.
module linear_probe_hash_table_top (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  lpht_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output lpht_pkg::rsp_t rsp
);

  // Command and status between the sequencer and the datapath
  lpht_pkg::cmd_t cmd;
  lpht_pkg::sts_t sts;

  // Sequencer: idle, walk the probe, then commit once the response
  // register is free.
  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Datapath: valid map, key and value RAMs, probe pointer, hit and
  // first-empty tracking, occupancy count and the response register.
  lpht_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

endmodule
